/* sv/bt_pkg.sv */
// Shared types and constants for the binary thinning pass.
package bt_pkg;

  localparam int PIX_W = 8;
  localparam int DIM_CFG_W = 11;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W = 2;

  localparam logic [PIX_W-1:0] THRESH_RESET = 8'd210;
  localparam logic [DIM_CFG_W-1:0] WIDTH_RESET = 11'd640;
  localparam logic [DIM_CFG_W-1:0] HEIGHT_RESET = 11'd480;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_WIDTH     = 2'd1,
    CFG_HEIGHT    = 2'd2,
    CFG_PASS      = 2'd3
  } cfg_idx_t;

  // Position flags of one beat, worked out when the beat is accepted.
  typedef struct packed {
    logic bit_v;    // binarized pixel entering the window
    logic have;     // a window center exists for this beat
    logic top_e;    // center sits on the first row
    logic bot_e;    // center sits on the last row
    logic left_e;   // center sits on the first column
    logic right_e;  // center sits on the last column
    logic last;     // center is the final pixel of the frame
    logic restart;  // frame restarted before this beat
  } pos_t;

  typedef struct packed {
    logic pixel_out;
    logic removed;
    logic frame_removed;
    logic last_of_frame;
  } thin_res_t;

endpackage

/* sv/bt_line_mem.sv */
// Two-line buffer memory (above and current bit per column) with clearing sweep.
module bt_line_mem #(
  parameter int DEPTH = 1024,
  parameter int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [1:0]    rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [1:0]    wr_data,
  output logic          clr_done
);

  logic [1:0]    mem [DEPTH];
  logic [1:0]    rd_data_r;
  logic [AW-1:0] clr_cnt_r;
  logic          clr_done_r;
  logic          we;
  logic [AW-1:0] wa;
  logic [1:0]    wd;
  logic          byp;

  always_comb begin
    we  = wr_en || !clr_done_r;
    wa  = clr_done_r ? wr_addr : clr_cnt_r;
    wd  = clr_done_r ? wr_data : 2'b00;
    byp = wr_en && clr_done_r && (wr_addr == rd_addr);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r  <= '0;
      clr_done_r <= 1'b0;
    end else if (!clr_done_r) begin
      if (clr_cnt_r == AW'(DEPTH - 1)) begin
        clr_done_r <= 1'b1;
      end
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      rd_data_r <= byp ? wr_data : mem[rd_addr];
    end
  end

  assign rd_data  = rd_data_r;
  assign clr_done = clr_done_r;

endmodule

/* sv/bt_pos_ctrl.sv */
// Raster position counters, frame geometry clamping and edge flags.
module bt_pos_ctrl #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int CW = $clog2(MAX_WIDTH),
  parameter int WW = $clog2(MAX_WIDTH + 1),
  parameter int RW = $clog2(MAX_HEIGHT + 3)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            accept,
  input  logic                            cmd,
  input  logic [bt_pkg::PIX_W-1:0]        pixel,
  input  logic [bt_pkg::PIX_W-1:0]        threshold,
  input  logic [bt_pkg::DIM_CFG_W-1:0]    frame_width,
  input  logic [bt_pkg::DIM_CFG_W-1:0]    frame_height,
  output logic [CW-1:0]                   col,
  output bt_pkg::pos_t                    pos
);
  import bt_pkg::*;

  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [WW-1:0] w;
  logic [RW-1:0] h;

  always_comb begin
    if (frame_width == '0) begin
      w = WW'(1);
    end else if (32'(frame_width) > MAX_WIDTH) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = WW'(frame_width);
    end
    if (frame_height == '0) begin
      h = RW'(1);
    end else if (32'(frame_height) > MAX_HEIGHT) begin
      h = RW'(MAX_HEIGHT);
    end else begin
      h = RW'(frame_height);
    end
  end

  always_comb begin
    logic [WW-1:0] c0;
    logic [WW-1:0] c1;
    logic [WW-1:0] cc;
    logic [RW-1:0] r0;
    logic [RW-1:0] r1;
    logic [RW-1:0] cr;

    c0 = (WW'(col_r) >= w) ? '0 : WW'(col_r);
    r0 = row_r;
    pos.restart = (r0 > h + 1'b1) || ((r0 == h + 1'b1) && (c0 != '0));
    if (pos.restart) begin
      r0 = '0;
      c0 = '0;
    end

    pos.bit_v = (r0 < h) && !cmd && (pixel >= threshold);

    if (c0 != '0) begin
      pos.have = (r0 >= RW'(1));
      cr = r0 - 1'b1;
      cc = c0 - 1'b1;
    end else begin
      pos.have = (r0 >= RW'(2));
      cr = r0 - RW'(2);
      cc = w - 1'b1;
    end
    pos.top_e   = (cr == '0);
    pos.bot_e   = (cr == h - 1'b1);
    pos.left_e  = (cc == '0);
    pos.right_e = (cc == w - 1'b1);
    pos.last    = pos.bot_e && pos.right_e;

    c1 = c0 + 1'b1;
    r1 = r0;
    if (c1 >= w) begin
      c1 = '0;
      r1 = r0 + 1'b1;
    end
    if (pos.have && pos.last) begin
      c1 = '0;
      r1 = '0;
    end

    col     = c0[CW-1:0];
    col_nxt = accept ? c1[CW-1:0] : col_r;
    row_nxt = accept ? r1 : row_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

/* sv/bt_thin_core.sv */
// 3x3 window register, Guo-Hall removal test and sticky removal flag.
module bt_thin_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [1:0]        line_bits,
  input  bt_pkg::pos_t      pos,
  input  logic              pass_sel,
  output bt_pkg::thin_res_t res
);
  import bt_pkg::*;

  logic [8:0] win_r, win_nxt;
  logic       sticky_r, sticky_nxt;

  always_comb begin
    logic n0, n1, n2, n3, n4, n5, n6, n7, p;
    logic [2:0] c, na, nb, nmin;
    logic crit, rem, sticky_now;

    // Columns: bits 2:0 west, 5:3 middle, 8:6 east; each top, mid, bottom.
    win_nxt = {pos.bit_v, line_bits[0], line_bits[1], win_r[8:3]};

    n0 = win_nxt[0]; n7 = win_nxt[1]; n6 = win_nxt[2];
    n1 = win_nxt[3]; p  = win_nxt[4]; n5 = win_nxt[5];
    n2 = win_nxt[6]; n3 = win_nxt[7]; n4 = win_nxt[8];

    if (pos.top_e) begin
      n0 = 1'b0; n1 = 1'b0; n2 = 1'b0;
    end
    if (pos.bot_e) begin
      n4 = 1'b0; n5 = 1'b0; n6 = 1'b0;
    end
    if (pos.left_e) begin
      n0 = 1'b0; n7 = 1'b0; n6 = 1'b0;
    end
    if (pos.right_e) begin
      n2 = 1'b0; n3 = 1'b0; n4 = 1'b0;
    end

    c = 3'(!n1 && (n2 || n3)) + 3'(!n3 && (n4 || n5))
      + 3'(!n5 && (n6 || n7)) + 3'(!n7 && (n0 || n1));
    na = 3'(n0 || n1) + 3'(n2 || n3) + 3'(n4 || n5) + 3'(n6 || n7);
    nb = 3'(n1 || n2) + 3'(n3 || n4) + 3'(n5 || n6) + 3'(n7 || n0);
    nmin = (na < nb) ? na : nb;
    if (!pass_sel) begin
      crit = (n1 || n2 || !n4) && n3;
    end else begin
      crit = (n5 || n6 || !n0) && n7;
    end

    rem = p && (c == 3'd1) && ((nmin == 3'd2) || (nmin == 3'd3)) && !crit;

    sticky_now = (pos.restart ? 1'b0 : sticky_r) || (pos.have && rem);
    sticky_nxt = (pos.have && pos.last) ? 1'b0 : sticky_now;

    res.pixel_out     = p && !rem;
    res.removed       = rem;
    res.frame_removed = sticky_now;
    res.last_of_frame = pos.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r    <= '0;
      sticky_r <= 1'b0;
    end else if (step) begin
      win_r    <= win_nxt;
      sticky_r <= sticky_nxt;
    end
  end

endmodule

/* sv/binary_thinning_pass.sv */
// Top level of the streaming Guo-Hall thinning sub-iteration.
// Throughput: one beat per clock unless the output stalls. An accepted beat waits in
// stage 1, then enters the output register if it has a window center; the result of a
// pixel comes out with the beat that arrives frame_width + 1 beats after it (trailing
// flush beats drain the frame). Reset (rst_n low, synchronous) clears control state and
// then starts a clearing sweep of the whole line memory, during which in_tready is low.
module binary_thinning_pass #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input stream.
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [7:0]                       in_tdata,   // [7:0] pixel
  input  logic                             in_tuser,   // [0] cmd (1 = flush beat)
  // Result stream.
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [7:0]                       out_tdata,  // [0] pixel_out, [1] removed,
                                                       // [2] frame_removed, [7:3] zero
  output logic                             out_tlast,  // last_of_frame
  // Configuration write channel.
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bt_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import bt_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);

  // Configuration registers.
  logic [PIX_W-1:0]     thresh_r;
  logic [DIM_CFG_W-1:0] width_r;
  logic [DIM_CFG_W-1:0] height_r;
  logic                 pass_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= THRESH_RESET;
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
      pass_r   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_THRESHOLD: thresh_r <= cfg_data[PIX_W-1:0];
        CFG_WIDTH:     width_r  <= cfg_data[DIM_CFG_W-1:0];
        CFG_HEIGHT:    height_r <= cfg_data[DIM_CFG_W-1:0];
        CFG_PASS:      pass_r   <= cfg_data[0];
        default:       pass_r   <= pass_r;
      endcase
    end
  end

  // Handshake. Stage 1 holds an accepted beat while its line memory read
  // completes; a beat without a window center leaves stage 1 without
  // needing the output register.
  logic          accept;
  logic          clr_done;
  logic          s1_v_r;
  pos_t          s1_pos_r;
  logic [CW-1:0] s1_col_r;
  logic          s1_adv;
  logic          out_v_r;
  thin_res_t     out_res_r;

  logic [CW-1:0] in_col;
  pos_t          in_pos;
  logic [1:0]    line_bits;
  thin_res_t     core_res;

  assign s1_adv    = s1_v_r && (!s1_pos_r.have || !out_v_r || out_tready);
  assign in_tready = clr_done && (!s1_v_r || s1_adv);
  assign accept    = in_tvalid && in_tready;

  bt_pos_ctrl #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_pos (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .cmd         (in_tuser),
    .pixel       (in_tdata),
    .threshold   (thresh_r),
    .frame_width (width_r),
    .frame_height(height_r),
    .col         (in_col),
    .pos         (in_pos)
  );

  // Each memory word holds {row above, current row} for one column. The
  // read happens on acceptance; stage 1 writes back {current, new bit}.
  bt_line_mem #(
    .DEPTH(MAX_WIDTH)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (in_col),
    .rd_data (line_bits),
    .wr_en   (s1_adv),
    .wr_addr (s1_col_r),
    .wr_data ({line_bits[0], s1_pos_r.bit_v}),
    .clr_done(clr_done)
  );

  bt_thin_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (s1_adv),
    .line_bits(line_bits),
    .pos      (s1_pos_r),
    .pass_sel (pass_r),
    .res      (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (accept) begin
      s1_v_r <= 1'b1;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pos_r <= in_pos;
      s1_col_r <= in_col;
    end
  end

  // Output register: loaded when stage 1 delivers a result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_adv && s1_pos_r.have) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_pos_r.have) begin
      out_res_r <= core_res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {5'b0, out_res_r.frame_removed, out_res_r.removed,
                       out_res_r.pixel_out};
  assign out_tlast  = out_res_r.last_of_frame;

endmodule

/* dv/tb_binary_thinning_pass.sv */
// Self-checking testbench for the streaming Guo-Hall thinning pass.
`timescale 1ns / 1ps

module tb_binary_thinning_pass;
  import bt_pkg::*;

  localparam int MAX_W = 1024;
  localparam int MAX_H = 1024;
  // An accepted beat passes only stage 1 before it reaches the output register, so
  // SETTLE_CYCLES quiet cycles are enough for any beat without a result to leave the pipe.
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_BEATS = 420;
  localparam int SHOW_ERRORS = 10;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [7:0] in_tdata = '0;  // [7:0] pixel
  logic in_tuser = 1'b0;      // [0] cmd (1 = flush beat)

  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [7:0] out_tdata;      // [0] pixel_out, [1] removed, [2] frame_removed
  logic out_tlast;

  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  binary_thinning_pass #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the block: register values as last written, the two line
  // buffers, the sliding 3x3 window and the raster position of the next beat.
  logic [7:0] cfg_thresh = THRESH_RESET;
  logic [10:0] cfg_width = WIDTH_RESET;
  logic [10:0] cfg_height = HEIGHT_RESET;
  logic cfg_pass = 1'b0;

  logic [MAX_W-1:0] line_above_q = '0;
  logic [MAX_W-1:0] line_cur_q = '0;
  logic [8:0] win_q = '0;
  logic [9:0] pos_col = '0;
  logic [10:0] pos_row = '0;
  logic frame_removed_q = 1'b0;

  // Thinned pixels the block still owes us, oldest first.
  thin_res_t thinned_q[$];

  int err_count = 0;
  int beats_sent = 0;
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;
  int rx_hold_pending = 0;

  // A register value of zero acts as one; values above the buffer size saturate.
  function automatic int dim_eff(input logic [10:0] v, input int maxv);
    if (v == 0) return 1;
    return (int'(v) > maxv) ? maxv : int'(v);
  endfunction

  // Mostly short pauses, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Gray value that lands on the foreground side of the threshold with the
  // given odds; one value in ten is left fully random.
  function automatic logic [7:0] gen_pixel(input int fg_pct);
    logic [7:0] v;
    v = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 9) == 0) return v;
    if ($urandom_range(1, 100) <= fg_pct) begin
      v = 8'($urandom_range(int'(cfg_thresh), 255));
    end else if (cfg_thresh != 0) begin
      v = 8'($urandom_range(0, int'(cfg_thresh) - 1));
    end
    return v;
  endfunction

  // Advances the shadow by one accepted beat and queues the thinned pixel
  // of the window center, if the window has a center inside the frame.
  function automatic void thin_predict(input logic cmd, input logic [7:0] pix);
    int w, h, col, cr, cc, c, na, nb, nmin;
    logic bit_in, top_b, mid_b, have;
    logic n0, n1, n2, n3, n4, n5, n6, n7, p, crit, rem, is_last;
    logic [8:0] nw;
    thin_res_t res;

    w = dim_eff(cfg_width, MAX_W);
    h = dim_eff(cfg_height, MAX_H);

    // A geometry write may leave the position outside the new frame.
    if (int'(pos_col) >= w) pos_col = '0;
    if (int'(pos_row) > h + 1 || (int'(pos_row) == h + 1 && pos_col != 0)) begin
      pos_row = '0;
      pos_col = '0;
      frame_removed_q = 1'b0;
    end

    // Flush beats and anything past the last row count as background.
    bit_in = (int'(pos_row) < h) && !cmd && (pix >= cfg_thresh);
    col = int'(pos_col);
    top_b = line_above_q[col];
    mid_b = line_cur_q[col];
    line_above_q[col] = mid_b;
    line_cur_q[col] = bit_in;
    // Window columns west to east in bits [2:0], [5:3], [8:6]; top row lowest.
    win_q = {bit_in, mid_b, top_b, win_q[8:3]};

    if (col >= 1) begin
      have = (pos_row >= 11'd1);
      cr = int'(pos_row) - 1;
      cc = col - 1;
    end else begin
      have = (pos_row >= 11'd2);
      cr = int'(pos_row) - 2;
      cc = w - 1;
    end

    if (col + 1 >= w) begin
      pos_col = '0;
      pos_row = pos_row + 1'b1;
    end else begin
      pos_col = pos_col + 1'b1;
    end

    if (!have) return;

    // Neighbors that fall outside the frame read as zero.
    nw = win_q;
    if (cr == 0) begin
      nw[0] = 1'b0; nw[3] = 1'b0; nw[6] = 1'b0;
    end
    if (cr == h - 1) begin
      nw[2] = 1'b0; nw[5] = 1'b0; nw[8] = 1'b0;
    end
    if (cc == 0) begin
      nw[0] = 1'b0; nw[1] = 1'b0; nw[2] = 1'b0;
    end
    if (cc == w - 1) begin
      nw[6] = 1'b0; nw[7] = 1'b0; nw[8] = 1'b0;
    end
    // Clockwise from the north-west corner: n0 NW, n1 N, n2 NE, n3 E,
    // n4 SE, n5 S, n6 SW, n7 W.
    n0 = nw[0]; n7 = nw[1]; n6 = nw[2];
    n1 = nw[3]; p = nw[4]; n5 = nw[5];
    n2 = nw[6]; n3 = nw[7]; n4 = nw[8];

    c = int'(!n1 && (n2 || n3)) + int'(!n3 && (n4 || n5))
      + int'(!n5 && (n6 || n7)) + int'(!n7 && (n0 || n1));
    na = int'(n0 || n1) + int'(n2 || n3) + int'(n4 || n5) + int'(n6 || n7);
    nb = int'(n1 || n2) + int'(n3 || n4) + int'(n5 || n6) + int'(n7 || n0);
    nmin = (na < nb) ? na : nb;
    if (!cfg_pass) crit = (n1 || n2 || !n4) && n3;
    else crit = (n5 || n6 || !n0) && n7;

    rem = p && (c == 1) && (nmin == 2 || nmin == 3) && !crit;
    frame_removed_q = frame_removed_q | rem;
    is_last = (cr == h - 1) && (cc == w - 1);

    res.pixel_out = p & ~rem;
    res.removed = rem;
    res.frame_removed = frame_removed_q;
    res.last_of_frame = is_last;
    thinned_q = {thinned_q, res};

    if (is_last) begin
      pos_row = '0;
      pos_col = '0;
      frame_removed_q = 1'b0;
    end
  endfunction

  // Offers one beat, possibly after a pause, and returns at the edge that
  // accepts it. Valid is left high so the next beat can follow at once.
  task automatic send_beat(input logic cmd, input logic [7:0] pix);
    int gap;
    gap = (tx_calm || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= pix;
    do @(posedge clk); while (!in_tready);
    thin_predict(cmd, pix);
    beats_sent++;
  endtask

  // Register writes go back to back; end_cfg drops valid after the group.
  task automatic write_reg(input cfg_idx_t idx, input logic [10:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_THRESHOLD: cfg_thresh = val[7:0];
      CFG_WIDTH: cfg_width = val;
      CFG_HEIGHT: cfg_height = val;
      CFG_PASS: cfg_pass = val[0];
      default: ;
    endcase
  endtask

  task automatic end_cfg();
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(input logic [7:0] thr, input logic [10:0] w,
                           input logic [10:0] h, input logic pass_sel);
    write_reg(CFG_THRESHOLD, {3'b000, thr});
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    write_reg(CFG_PASS, {10'd0, pass_sel});
    end_cfg();
  endtask

  // Stops offering beats until every owed pixel has arrived, then lets the
  // pipeline settle so that a register write finds the block quiet.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (thinned_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Drains the current frame with a mix of flush beats and pixel beats,
  // which the block treats as background once the frame rows are done.
  task automatic finish_frame();
    while (pos_row != 0 || pos_col != 0) begin
      send_beat($urandom_range(0, 2) != 0, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic send_frame(input int fg_pct);
    int w, h;
    w = dim_eff(cfg_width, MAX_W);
    h = dim_eff(cfg_height, MAX_H);
    for (int i = 0; i < w * h; i++) begin
      send_beat($urandom_range(0, 19) == 0, gen_pixel(fg_pct));
    end
    finish_frame();
  endtask

  // Threshold and pass come from reset. The center of the 3x3 frame has
  // foreground to the north, north-west and west only, which the first
  // sub-iteration removes. A flush beat carrying 255 sits inside the frame
  // and a bright pixel beat arrives after the frame rows.
  task automatic test_reset_config();
    write_reg(CFG_WIDTH, 11'd3);
    write_reg(CFG_HEIGHT, 11'd3);
    end_cfg();
    send_beat(1'b0, 8'd255);
    send_beat(1'b0, 8'd210);
    send_beat(1'b0, 8'd0);
    send_beat(1'b0, 8'd255);
    send_beat(1'b0, 8'd211);
    send_beat(1'b0, 8'd209);
    send_beat(1'b1, 8'd255);
    send_beat(1'b0, 8'd0);
    send_beat(1'b0, 8'd128);
    send_beat(1'b1, 8'd0);
    send_beat(1'b0, 8'd255);
    send_beat(1'b1, 8'd255);
    send_beat(1'b0, 8'd7);
    wait_idle();
  endtask

  // Zero width and height act as a single pixel frame; then the highest
  // threshold with the mirrored pattern that the second sub-iteration removes.
  task automatic test_bad_geometry();
    configure(8'd0, 11'd0, 11'd0, 1'b1);
    send_beat(1'b0, 8'd0);
    send_beat(1'b1, 8'd0);
    send_beat(1'b1, 8'd255);
    wait_idle();

    configure(8'd255, 11'd3, 11'd3, 1'b1);
    send_beat(1'b0, 8'd0);
    send_beat(1'b0, 8'd0);
    send_beat(1'b0, 8'd254);
    send_beat(1'b0, 8'd0);
    send_beat(1'b0, 8'd255);
    send_beat(1'b0, 8'd255);
    send_beat(1'b0, 8'd0);
    send_beat(1'b0, 8'd255);
    send_beat(1'b0, 8'd255);
    finish_frame();
    wait_idle();
  endtask

  // Width and height above the buffer size saturate. A short stretch runs
  // at the saturated geometry, then a smaller geometry brings the frame to
  // a quick end: first a column wrap, then a last row reached at once.
  task automatic test_geometry_extremes();
    configure(8'($urandom_range(1, 254)), 11'd2047, 11'd2047, 1'b0);
    repeat (24) send_beat(1'b0, gen_pixel(60));
    wait_idle();
    write_reg(CFG_WIDTH, 11'd4);
    write_reg(CFG_HEIGHT, 11'd3);
    end_cfg();
    finish_frame();
    wait_idle();

    configure(8'($urandom_range(1, 254)), 11'd1, 11'd2047, 1'b1);
    repeat (6) send_beat(1'b0, gen_pixel(60));
    wait_idle();
    write_reg(CFG_HEIGHT, 11'd5);
    end_cfg();
    finish_frame();
    wait_idle();
  endtask

  // The receiver holds off for a long stretch while beats keep coming, so
  // the output fills and the input side has to stall.
  task automatic test_backpressure();
    configure(8'd128, 11'd16, 11'd8, 1'($urandom_range(0, 1)));
    tx_calm = 1'b1;
    rx_hold_pending = 300;
    send_frame(65);
    tx_calm = 1'b0;
    wait_idle();
  endtask

  // Geometry writes in the middle of a frame: a column beyond a narrower
  // width wraps, a position beyond a shorter frame restarts it, and a
  // wider row keeps the position.
  task automatic test_geometry_change();
    configure(8'd100, 11'd8, 11'd6, 1'b0);
    repeat (20) send_beat(1'b0, gen_pixel(60));
    wait_idle();
    write_reg(CFG_WIDTH, 11'd3);
    end_cfg();
    repeat (7) send_beat(1'b0, gen_pixel(60));
    wait_idle();
    write_reg(CFG_HEIGHT, 11'd1);
    end_cfg();
    finish_frame();
    wait_idle();

    configure(8'd100, 11'd5, 11'd4, 1'b1);
    repeat (7) send_beat(1'b0, gen_pixel(60));
    wait_idle();
    write_reg(CFG_WIDTH, 11'd9);
    end_cfg();
    finish_frame();
    wait_idle();
  endtask

  task automatic test_random_frames();
    int first, w, h, k;
    logic [7:0] thr;
    first = beats_sent;
    while (beats_sent - first < RANDOM_BEATS) begin
      tx_calm = ($urandom_range(0, 4) == 0);
      rx_calm = ($urandom_range(0, 4) == 0);
      k = $urandom_range(0, 9);
      thr = (k == 0) ? 8'd0 : (k == 1) ? 8'd255 : 8'($urandom_range(1, 254));
      k = $urandom_range(0, 99);
      w = (k < 5) ? 0 : (k < 10) ? 1 : (k < 90) ? $urandom_range(2, 10) : $urandom_range(11, 24);
      k = $urandom_range(0, 99);
      h = (k < 5) ? 0 : (k < 10) ? 1 : (k < 90) ? $urandom_range(2, 10) : $urandom_range(11, 24);
      configure(thr, 11'(w), 11'(h), 1'($urandom_range(0, 1)));

      if ($urandom_range(0, 7) == 0) begin
        // Broken frame: part of it, a quiet pause, new settings, then the rest.
        w = dim_eff(cfg_width, MAX_W) * dim_eff(cfg_height, MAX_H);
        k = (w > 1) ? $urandom_range(1, w - 1) : 1;
        repeat (k) send_beat($urandom_range(0, 19) == 0, gen_pixel(60));
        wait_idle();
        configure(8'($urandom_range(0, 255)), 11'($urandom_range(0, 12)),
                  11'($urandom_range(0, 8)), 1'($urandom_range(0, 1)));
        finish_frame();
      end else begin
        send_frame($urandom_range(40, 80));
      end
      wait_idle();
    end
    tx_calm = 1'b0;
    rx_calm = 1'b0;
  endtask

  // Receiver pacing. A requested hold-off is counted out here, apart from
  // the sender, so that beats keep being offered while results back up.
  initial begin : rx_pacing
    int stall;
    @(posedge clk);
    forever begin
      stall = 0;
      if (rx_hold_pending > 0) begin
        stall = rx_hold_pending;
        rx_hold_pending = 0;
      end else if (!rx_calm && $urandom_range(0, 3) == 0) begin
        stall = pick_gap();
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
    end
  end

  // Every accepted result beat is matched against the oldest owed pixel.
  always @(posedge clk) begin : result_check
    thin_res_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.pixel_out = out_tdata[0];
      got.removed = out_tdata[1];
      got.frame_removed = out_tdata[2];
      got.last_of_frame = out_tlast;
      if (thinned_q.size() == 0) begin
        err_count++;
        if (err_count <= SHOW_ERRORS) begin
          $display("[%0t] unexpected result beat: out=%b rm=%b frm=%b last=%b", $time,
                   got.pixel_out, got.removed, got.frame_removed, got.last_of_frame);
        end
      end else begin
        want = thinned_q.pop_front();
        if (got.pixel_out !== want.pixel_out || got.removed !== want.removed ||
            got.frame_removed !== want.frame_removed ||
            got.last_of_frame !== want.last_of_frame) begin
          err_count++;
          if (err_count <= SHOW_ERRORS) begin
            $display("[%0t] result mismatch: expected out=%b rm=%b frm=%b last=%b,",
                     $time, want.pixel_out, want.removed, want.frame_removed,
                     want.last_of_frame, " got out=%b rm=%b frm=%b last=%b",
                     got.pixel_out, got.removed, got.frame_removed, got.last_of_frame);
          end
        end
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_config();
    test_bad_geometry();
    test_geometry_extremes();
    test_backpressure();
    test_geometry_change();
    test_random_frames();
    wait_idle();
    if (err_count == 0) begin
      $display("tb_binary_thinning_pass OK");
    end else begin
      $display("tb_binary_thinning_pass NOT OK");
    end
    $finish;
  end

  // Far beyond the slowest legal run, including the line-buffer clearing
  // sweep after reset.
  initial begin
    #5_000_000;
    $display("tb_binary_thinning_pass NOT OK");
    $finish;
  end

endmodule
